>>> hw/rtl/rcp_pkg.sv
// ----------------------------------------------------------------------------
// rcp_pkg: shared types and constants of the command parser
// Character codes, error codes, field widths and the result record.
// ----------------------------------------------------------------------------
package rcp_pkg;

    // Field widths of one result
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned WORDNO_W = 16;
    localparam int unsigned ERR_W    = 3;

    // Framing characters
    localparam logic [BYTE_W-1:0] CHAR_STAR   = 8'h2A;  // '*'
    localparam logic [BYTE_W-1:0] CHAR_DOLLAR = 8'h24;  // '$'
    localparam logic [BYTE_W-1:0] CHAR_ZERO   = 8'h30;  // '0'
    localparam logic [BYTE_W-1:0] CHAR_NINE   = 8'h39;  // '9'
    localparam logic [BYTE_W-1:0] CHAR_UP_A   = 8'h41;  // 'A'
    localparam logic [BYTE_W-1:0] CHAR_UP_Z   = 8'h5A;  // 'Z'
    localparam logic [BYTE_W-1:0] CASE_OFFSET = 8'h20;  // upper to lower

    // Number of bytes skipped after a payload
    localparam logic [1:0] SKIP_COUNT = 2'd2;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_NONE       = 3'd0;
    localparam logic [ERR_W-1:0] ERR_NO_STAR    = 3'd1;
    localparam logic [ERR_W-1:0] ERR_NO_DOLLAR  = 3'd2;
    localparam logic [ERR_W-1:0] ERR_EMPTY_CMD  = 3'd3;
    localparam logic [ERR_W-1:0] ERR_OVERFLOW   = 3'd4;

    // One result transaction
    typedef struct packed {
        logic [BYTE_W-1:0]   out_byte;
        logic [WORDNO_W-1:0] word_number;
        logic                has_byte;
        logic                last_of_word;
        logic                last_of_command;
        logic [ERR_W-1:0]    error_code;
    } t_result;

endpackage

>>> hw/rtl/resp_command_parser_unit.sv
// ----------------------------------------------------------------------------
// resp_command_parser_unit: byte-stream parser for array-of-strings commands
// Parses '*'<count>.. then per word '$'<len>..<payload>.. and streams out
// the payload bytes tagged with their word index.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes one command byte per transaction. The master
//   stream returns at most one result per input byte: a payload byte (with
//   has_byte set), a marker for an empty word, or an error marker.
//   Letters of word 0 leave lower-cased. tlast flags the end of a command.
// Throughput and timing:
//   One byte is taken every clock cycle while tready is high. A result
//   appears on the master side in the cycle after the byte that causes it;
//   the parse state and the digit-accumulate step (shift-add by ten and a
//   width check) sit between the slave port and a single result register.
// Stall:
//   tready on the slave side is low only when the result register is full
//   and not taken; while a result waits on a low tready no byte is taken.
// Reset:
//   i_rst_n clears the parser to wait for '*' and empties the result
//   register. Framing errors report once, then bytes are dropped up to '*'.
// ----------------------------------------------------------------------------
module resp_command_parser_unit #(
    parameter int unsigned COUNT_WIDTH  = 16,
    parameter int unsigned LENGTH_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] in_byte
    // master stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [7:0] out_byte, [23:8] word_number,
                                          // [24] last_of_word, [31:25] zero
    output logic        o_m_axis_tlast,   // last_of_command
    output logic [3:0]  o_m_axis_tuser    // [0] has_byte, [3:1] error_code
);

    localparam int unsigned ACC_W  = (COUNT_WIDTH > LENGTH_WIDTH) ? COUNT_WIDTH
                                                                   : LENGTH_WIDTH;
    localparam int unsigned PROD_W = ACC_W + 4;

    // Parse phases
    localparam logic [2:0] PH_STAR       = 3'd0;
    localparam logic [2:0] PH_RESYNC     = 3'd1;
    localparam logic [2:0] PH_COUNT      = 3'd2;
    localparam logic [2:0] PH_COUNT_SKIP = 3'd3;
    localparam logic [2:0] PH_DOLLAR     = 3'd4;
    localparam logic [2:0] PH_LEN        = 3'd5;
    localparam logic [2:0] PH_LEN_SKIP   = 3'd6;
    localparam logic [2:0] PH_PAYLOAD    = 3'd7;

    logic [2:0]              r_phase,      n_phase;
    logic [ACC_W-1:0]        r_accum,      n_accum;
    logic [COUNT_WIDTH-1:0]  r_words_left, n_words_left;
    logic [LENGTH_WIDTH-1:0] r_bytes_left, n_bytes_left;
    logic [COUNT_WIDTH-1:0]  r_word_index, n_word_index;
    logic [1:0]              r_skip_left,  n_skip_left;
    logic                    r_out_valid,  n_out_valid;
    rcp_pkg::t_result        r_result,     n_result;

    logic                    in_accept;
    logic                    res_valid;
    logic [7:0]              in_byte;
    logic                    is_digit;
    logic [3:0]              digit_val;
    logic [PROD_W-1:0]       prod;
    logic                    count_ovf;
    logic                    len_ovf;
    logic [LENGTH_WIDTH-1:0] bytes_dec;
    logic [COUNT_WIDTH-1:0]  words_dec;
    logic [1:0]              skip_dec;
    logic [7:0]              low_byte;

    assign in_byte         = i_s_axis_tdata;
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    // Decode digit and build the next decimal value
    assign is_digit  = in_byte inside {[rcp_pkg::CHAR_ZERO:rcp_pkg::CHAR_NINE]};
    assign digit_val = 4'(in_byte - rcp_pkg::CHAR_ZERO);
    assign prod      = PROD_W'({r_accum, 3'b000}) + PROD_W'({r_accum, 1'b0})
                     + PROD_W'(digit_val);
    assign count_ovf = (prod >> COUNT_WIDTH) != '0;
    assign len_ovf   = (prod >> LENGTH_WIDTH) != '0;

    assign bytes_dec = r_bytes_left - LENGTH_WIDTH'(1);
    assign words_dec = r_words_left - COUNT_WIDTH'(1);
    assign skip_dec  = (r_skip_left != 2'd0) ? (r_skip_left - 2'd1) : 2'd0;

    // Lower-case letters of the command name
    always_comb begin
        low_byte = in_byte;
        if ((r_word_index == '0) &&
            (in_byte inside {[rcp_pkg::CHAR_UP_A:rcp_pkg::CHAR_UP_Z]})) begin
            low_byte = in_byte + rcp_pkg::CASE_OFFSET;
        end
    end

    // Advance the parser by one byte
    always_comb begin
        n_phase      = r_phase;
        n_accum      = r_accum;
        n_words_left = r_words_left;
        n_bytes_left = r_bytes_left;
        n_word_index = r_word_index;
        n_skip_left  = r_skip_left;
        res_valid    = 1'b0;

        n_result.out_byte        = '0;
        n_result.word_number     = rcp_pkg::WORDNO_W'(r_word_index);
        n_result.has_byte        = 1'b0;
        n_result.last_of_word    = 1'b0;
        n_result.last_of_command = 1'b0;
        n_result.error_code      = rcp_pkg::ERR_NONE;

        case (r_phase)
            PH_STAR: begin
                if (in_byte != rcp_pkg::CHAR_STAR) begin
                    res_valid           = 1'b1;
                    n_result.error_code = rcp_pkg::ERR_NO_STAR;
                    n_phase             = PH_RESYNC;
                end else begin
                    n_phase      = PH_COUNT;
                    n_accum      = '0;
                    n_word_index = '0;
                end
            end
            PH_RESYNC: begin
                if (in_byte == rcp_pkg::CHAR_STAR) begin
                    n_phase      = PH_COUNT;
                    n_accum      = '0;
                    n_word_index = '0;
                end
            end
            PH_COUNT: begin
                if (is_digit) begin
                    if (count_ovf) begin
                        res_valid           = 1'b1;
                        n_result.error_code = rcp_pkg::ERR_OVERFLOW;
                        n_phase             = PH_RESYNC;
                    end else begin
                        n_accum = ACC_W'(prod);
                    end
                end else if (r_accum == '0) begin
                    res_valid           = 1'b1;
                    n_result.error_code = rcp_pkg::ERR_EMPTY_CMD;
                    n_phase             = PH_RESYNC;
                end else begin
                    n_words_left = r_accum[COUNT_WIDTH-1:0];
                    n_phase      = PH_COUNT_SKIP;
                end
            end
            PH_COUNT_SKIP: begin
                n_phase = PH_DOLLAR;
            end
            PH_DOLLAR: begin
                if (in_byte != rcp_pkg::CHAR_DOLLAR) begin
                    res_valid           = 1'b1;
                    n_result.error_code = rcp_pkg::ERR_NO_DOLLAR;
                    n_phase             = PH_RESYNC;
                end else begin
                    n_accum = '0;
                    n_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                if (is_digit) begin
                    if (len_ovf) begin
                        res_valid           = 1'b1;
                        n_result.error_code = rcp_pkg::ERR_OVERFLOW;
                        n_phase             = PH_RESYNC;
                    end else begin
                        n_accum = ACC_W'(prod);
                    end
                end else begin
                    n_bytes_left = r_accum[LENGTH_WIDTH-1:0];
                    n_phase      = PH_LEN_SKIP;
                end
            end
            PH_LEN_SKIP: begin
                n_phase     = PH_PAYLOAD;
                n_skip_left = rcp_pkg::SKIP_COUNT;
                // Empty word: one marker
                if (r_bytes_left == '0) begin
                    n_words_left             = words_dec;
                    res_valid                = 1'b1;
                    n_result.last_of_word    = 1'b1;
                    n_result.last_of_command = (words_dec == '0);
                end
            end
            PH_PAYLOAD: begin
                if (r_bytes_left != '0) begin
                    // Pass the payload byte
                    res_valid         = 1'b1;
                    n_result.out_byte = low_byte;
                    n_result.has_byte = 1'b1;
                    n_bytes_left      = bytes_dec;
                    if (bytes_dec == '0) begin
                        n_words_left             = words_dec;
                        n_result.last_of_word    = 1'b1;
                        n_result.last_of_command = (words_dec == '0);
                    end
                end else begin
                    // Drop the trailing bytes, then move to the next word or, after the last word, back to '*'
                    n_skip_left = skip_dec;
                    if (skip_dec == 2'd0) begin
                        n_word_index = r_word_index + COUNT_WIDTH'(1);
                        n_phase      = (r_words_left == '0) ? PH_STAR : PH_DOLLAR;
                    end
                end
            end
            default: begin
                n_phase = PH_STAR;
            end
        endcase
    end

    // Hold the result until taken
    always_comb begin
        if (in_accept && res_valid) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_STAR;
            r_accum      <= '0;
            r_words_left <= '0;
            r_bytes_left <= '0;
            r_word_index <= '0;
            r_skip_left  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (in_accept) begin
                r_phase      <= n_phase;
                r_accum      <= n_accum;
                r_words_left <= n_words_left;
                r_bytes_left <= n_bytes_left;
                r_word_index <= n_word_index;
                r_skip_left  <= n_skip_left;
            end
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (in_accept && res_valid) begin
            r_result <= n_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'b0000000, r_result.last_of_word,
                              r_result.word_number, r_result.out_byte};
    assign o_m_axis_tlast  = r_result.last_of_command;
    assign o_m_axis_tuser  = {r_result.error_code, r_result.has_byte};

endmodule
